// ===== rtl/core/frm_rms_pkg.sv =====
// Shared widths, types and helper functions for the frame AC RMS meter.
package frm_rms_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int SQUARE_W      = 2 * SAMPLE_W - 1;
  localparam int LEVEL_W       = 15;
  localparam int LENGTH_W      = 11;
  localparam int MAX_FRAME_DEF = 1024;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUB,
    ST_SQRT,
    ST_DIV,
    ST_EMIT
  } frm_rms_state_t;

  typedef struct packed {
    logic load;
    logic mul_step;
    logic sub;
    logic sqrt_step;
    logic div_step;
    logic emit;
  } frm_rms_cmd_t;

  typedef struct packed {
    logic snap_valid;
    logic out_free;
  } frm_rms_status_t;

  // Sample counter width: must hold max_frame itself.
  function automatic int cnt_width(int max_frame);
    return $clog2(max_frame + 1);
  endfunction

  // Root width: |sum| and the square root of n*sumsq both fit here.
  function automatic int root_width(int max_frame);
    return cnt_width(max_frame) + SAMPLE_W - 1;
  endfunction

endpackage

// ===== rtl/core/frm_rms_if.sv =====
// Sample and level stream interfaces with valid/ready handshake.
interface frm_rms_sample_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [frm_rms_pkg::SAMPLE_W-1:0]    sample;
  logic                                       last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface frm_rms_level_if;
  logic                                valid;
  logic                                ready;
  logic [frm_rms_pkg::LEVEL_W-1:0]     level;
  logic [frm_rms_pkg::LENGTH_W-1:0]    frame_length;

  modport source (output valid, output level, output frame_length, input ready);
  modport sink   (input valid, input level, input frame_length, output ready);
endinterface

// ===== rtl/core/frame_ac_rms_meter.sv =====
// Top level of the frame AC RMS meter.
//
// Channels: samples (sink) takes one signed 16-bit sample per beat, with
// last_sample set on the final sample of a frame. levels (source) gives one
// beat per frame: level = floor(isqrt(n*sum(x^2) - sum(x)^2) / n), clamped
// to 15 bits, and frame_length = n. A frame that reaches MAX_FRAME samples
// is closed on that sample even without last_sample.
// Throughput: one sample per cycle within a frame. The closing beat fills a
// one-deep snapshot and ready stays low until the sequencer copies it out,
// in the cycle after the closing beat when the sequencer is idle; the next
// frame then accumulates while the sequencer works.
// Sequence: the bit-serial multiply, square root and divide take R steps
// each, R = clog2(MAX_FRAME+1) + 15. A frame that closes while the
// sequencer is still busy waits in the snapshot and holds ready low until
// the sequencer takes it.
// Reset: clears the accumulators and the valid flags of the snapshot and the output register.
// Stall: the level beat waits in its output register; the sequencer waits
// behind it, and samples keep flowing until a further frame closes.
module frame_ac_rms_meter #(
  parameter int MAX_FRAME = frm_rms_pkg::MAX_FRAME_DEF
) (
  input  logic             clk,
  input  logic             rst,
  frm_rms_sample_if.sink   samples,
  frm_rms_level_if.source  levels
);

  frm_rms_pkg::frm_rms_cmd_t    cmd;
  frm_rms_pkg::frm_rms_status_t status;

  frm_rms_ctrl #(
    .MAX_FRAME (MAX_FRAME)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  frm_rms_dp #(
    .MAX_FRAME (MAX_FRAME)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .levels  (levels),
    .cmd     (cmd),
    .status  (status)
  );

endmodule

// ===== rtl/core/frm_rms_ctrl.sv =====
// Sequencer for the end-of-frame multiply, square root and divide.
module frm_rms_ctrl #(
  parameter int MAX_FRAME = frm_rms_pkg::MAX_FRAME_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  frm_rms_pkg::frm_rms_status_t  status,
  output frm_rms_pkg::frm_rms_cmd_t     cmd
);

  localparam int RT_W   = frm_rms_pkg::root_width(MAX_FRAME);
  localparam int STEP_W = $clog2(RT_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(RT_W - 1);

  frm_rms_pkg::frm_rms_state_t state, state_next;
  logic [STEP_W-1:0]           step, step_next;
  logic                        stepping;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= frm_rms_pkg::ST_IDLE;
      step  <= STEP_LAST;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // Phase counter reloads itself when a phase ends.
  assign step_next = (stepping && step != '0) ? step - 1'b1 : STEP_LAST;

  always_comb begin
    state_next = state;
    cmd        = '0;
    stepping   = 1'b0;
    unique case (state)
      frm_rms_pkg::ST_IDLE: begin
        if (status.snap_valid) begin
          cmd.load   = 1'b1;
          state_next = frm_rms_pkg::ST_MUL;
        end
      end
      frm_rms_pkg::ST_MUL: begin
        cmd.mul_step = 1'b1;
        stepping     = 1'b1;
        if (step == '0) state_next = frm_rms_pkg::ST_SUB;
      end
      frm_rms_pkg::ST_SUB: begin
        cmd.sub    = 1'b1;
        state_next = frm_rms_pkg::ST_SQRT;
      end
      frm_rms_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        stepping      = 1'b1;
        if (step == '0) state_next = frm_rms_pkg::ST_DIV;
      end
      frm_rms_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        stepping     = 1'b1;
        if (step == '0) state_next = frm_rms_pkg::ST_EMIT;
      end
      frm_rms_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = frm_rms_pkg::ST_IDLE;
        end
      end
      default: state_next = frm_rms_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/frm_rms_dp.sv =====
// Accumulators, frame snapshot, shift-add multipliers, root, divider, output register.
module frm_rms_dp #(
  parameter int MAX_FRAME = frm_rms_pkg::MAX_FRAME_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  frm_rms_sample_if.sink                samples,
  frm_rms_level_if.source               levels,
  input  frm_rms_pkg::frm_rms_cmd_t     cmd,
  output frm_rms_pkg::frm_rms_status_t  status
);

  localparam int CNT_W  = frm_rms_pkg::cnt_width(MAX_FRAME);
  localparam int SUM_W  = CNT_W + frm_rms_pkg::SAMPLE_W;
  localparam int SQ_W   = CNT_W + frm_rms_pkg::SQUARE_W - 1;
  localparam int RT_W   = frm_rms_pkg::root_width(MAX_FRAME);
  localparam int PROD_W = 2 * RT_W;
  localparam logic [CNT_W-1:0] FRAME_LIMIT = CNT_W'(MAX_FRAME);

  // Accumulators
  logic [CNT_W-1:0]                  count;
  logic signed [SUM_W-1:0]           sum;
  logic [SQ_W-1:0]                   sq_sum;
  logic [CNT_W-1:0]                  count_next;
  logic signed [SUM_W-1:0]           sum_next;
  logic [SQ_W-1:0]                   sq_sum_next;
  logic signed [2*frm_rms_pkg::SAMPLE_W-1:0] sq_full;
  logic [frm_rms_pkg::SQUARE_W-1:0]  sq_term;
  logic                              accept;
  logic                              frame_end;

  // Snapshot of a finished frame
  logic                              snap_valid;
  logic [CNT_W-1:0]                  snap_n;
  logic signed [SUM_W-1:0]           snap_sum;
  logic [SQ_W-1:0]                   snap_sq;
  logic [RT_W-1:0]                   snap_mag;

  // Engine
  logic [CNT_W-1:0]                  frame_n;
  logic [CNT_W-1:0]                  n_shift;
  logic [PROD_W-1:0]                 mcand_a;
  logic [PROD_W-1:0]                 prod_a;
  logic [RT_W-1:0]                   mag_shift;
  logic [PROD_W-1:0]                 mcand_b;
  logic [PROD_W-1:0]                 prod_b;
  logic [PROD_W-1:0]                 work;
  logic [RT_W+1:0]                   rem;
  logic [RT_W-1:0]                   root;
  logic [CNT_W-1:0]                  drem;

  logic [RT_W+3:0]                   rem_sh;
  logic [RT_W+3:0]                   trial;
  logic                              sq_ge;
  logic [RT_W+3:0]                   sq_diff;
  logic [CNT_W:0]                    div_sh;
  logic                              div_ge;
  logic [CNT_W:0]                    div_diff;

  // Output register
  logic                              out_valid;
  logic [frm_rms_pkg::LEVEL_W-1:0]   out_level;
  logic [frm_rms_pkg::LENGTH_W-1:0]  out_length;
  logic [frm_rms_pkg::LEVEL_W-1:0]   level_clamped;

  assign samples.ready = !snap_valid;
  assign accept        = samples.valid && samples.ready;

  assign sq_full     = samples.sample * samples.sample;
  assign sq_term     = frm_rms_pkg::SQUARE_W'(sq_full);
  assign count_next  = count + 1'b1;
  assign sum_next    = sum + SUM_W'(samples.sample);
  assign sq_sum_next = sq_sum + SQ_W'(sq_term);
  assign frame_end   = samples.last_sample || (count_next == FRAME_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      sum        <= '0;
      sq_sum     <= '0;
      snap_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (frame_end) begin
          count      <= '0;
          sum        <= '0;
          sq_sum     <= '0;
          snap_valid <= 1'b1;
        end else begin
          count  <= count_next;
          sum    <= sum_next;
          sq_sum <= sq_sum_next;
        end
      end else if (cmd.load) begin
        snap_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && frame_end) begin
      snap_n   <= count_next;
      snap_sum <= sum_next;
      snap_sq  <= sq_sum_next;
    end
  end

  assign snap_mag = snap_sum[SUM_W-1] ? RT_W'(-snap_sum) : RT_W'(snap_sum);

  // Square root: two radicand bits per step
  assign rem_sh  = {rem, work[PROD_W-1 -: 2]};
  assign trial   = {2'b00, root, 2'b01};
  assign sq_ge   = rem_sh >= trial;
  assign sq_diff = rem_sh - trial;

  // Restoring divide of root by frame_n, quotient shifts into root
  assign div_sh   = {drem, root[RT_W-1]};
  assign div_ge   = div_sh >= {1'b0, frame_n};
  assign div_diff = div_sh - {1'b0, frame_n};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      frame_n   <= snap_n;
      n_shift   <= snap_n;
      mcand_a   <= PROD_W'(snap_sq);
      prod_a    <= '0;
      mag_shift <= snap_mag;
      mcand_b   <= PROD_W'(snap_mag);
      prod_b    <= '0;
    end
    if (cmd.mul_step) begin
      if (n_shift[0]) prod_a <= prod_a + mcand_a;
      if (mag_shift[0]) prod_b <= prod_b + mcand_b;
      n_shift   <= n_shift >> 1;
      mag_shift <= mag_shift >> 1;
      mcand_a   <= mcand_a << 1;
      mcand_b   <= mcand_b << 1;
    end
    if (cmd.sub) begin
      work <= (prod_a > prod_b) ? prod_a - prod_b : '0;
      rem  <= '0;
      root <= '0;
      drem <= '0;
    end
    if (cmd.sqrt_step) begin
      work <= work << 2;
      if (sq_ge) begin
        rem  <= sq_diff[RT_W+1:0];
        root <= {root[RT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[RT_W+1:0];
        root <= {root[RT_W-2:0], 1'b0};
      end
    end
    if (cmd.div_step) begin
      drem <= div_ge ? div_diff[CNT_W-1:0] : div_sh[CNT_W-1:0];
      root <= {root[RT_W-2:0], div_ge};
    end
  end

  assign level_clamped = (root > RT_W'(frm_rms_pkg::LEVEL_MAX)) ?
                         frm_rms_pkg::LEVEL_MAX : frm_rms_pkg::LEVEL_W'(root);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (levels.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_level  <= level_clamped;
      out_length <= frm_rms_pkg::LENGTH_W'(frame_n);
    end
  end

  assign levels.valid        = out_valid;
  assign levels.level        = out_level;
  assign levels.frame_length = out_length;

  assign status.snap_valid = snap_valid;
  assign status.out_free   = !out_valid || levels.ready;

endmodule
